FILE: rtl/fsp_pkg.sv
// Shared codes, field widths and stream packing offsets for the five-stage pipeline.
package fsp_pkg;

   // Item kind carried in req_tuser
   typedef enum logic [0:0] {
      KIND_LOAD = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   // Operation codes of a program slot
   typedef enum logic [1:0] {
      OP_MOV = 2'd0,
      OP_ADD = 2'd1,
      OP_SUB = 2'd2,
      OP_MUL = 2'd3
   } op_type;

   // Fixed field widths of the stream items
   localparam int SlotW   = 8;
   localparam int RegFldW = 4;
   localparam int ImmW    = 32;
   localparam int LenW    = 9;
   localparam int PcOutW  = 9;
   localparam int WbValW  = 32;

   // Request tdata layout, lowest bit first
   localparam int ReqSlotLo = 0;
   localparam int ReqOpLo   = ReqSlotLo + SlotW;
   localparam int ReqRdLo   = ReqOpLo + 2;
   localparam int ReqRaLo   = ReqRdLo + RegFldW;
   localparam int ReqRbLo   = ReqRaLo + RegFldW;
   localparam int ReqImmLo  = ReqRbLo + RegFldW;
   localparam int ReqUsedW  = ReqImmLo + ImmW;
   localparam int ReqDataW  = ((ReqUsedW + 7) / 8) * 8;

   // Response tdata layout, lowest bit first
   localparam int RspStallLo = 0;
   localparam int RspRegLo   = RspStallLo + 1;
   localparam int RspValLo   = RspRegLo + RegFldW;
   localparam int RspPcLo    = RspValLo + WbValW;
   localparam int RspUsedW   = RspPcLo + PcOutW;
   localparam int RspDataW   = ((RspUsedW + 7) / 8) * 8;

endpackage

FILE: rtl/five_stage_pipeline_with_forwarding_unit.sv
// Five-stage in-order pipeline (fetch, decode, execute, memory, writeback) with forwarding.
//
// A tick transfer on req clocks the modeled processor and produces exactly
// one rsp transfer (stall flag, writeback, PC after the tick, finished flag); a load
// transfer writes one program slot and produces nothing. One item is accepted every cycle
// while the response register is empty or being drained, so sustained throughput is one
// tick per clock. Program memory and the register file are synchronous-read
// arrays: the decode latch payload is the program memory read register, and the register
// file is read for the instruction entering execute as it leaves decode, with write-first
// bypass of the writeback done on that same tick. Register file entries read as zero
// until first written (per-entry valid bits); program slots are undefined until loaded.
// program_length is written through the csr channel, which is always ready.
module five_stage_pipeline_with_forwarding_unit #(
   parameter int REG_COUNT     = 16,
   parameter int PROGRAM_DEPTH = 256,
   parameter int DATA_WIDTH    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input item stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // slot_index[7:0], op_code[9:8], dest_reg[13:10], src_reg_a[17:14],
   // src_reg_b[21:18], immediate[53:22], zero fill[55:54]
   input  logic [fsp_pkg::ReqDataW-1:0]  req_tdata,
   // kind[0]
   input  logic [0:0]                    req_tuser,
   // Result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // stalled[0], wb_reg[4:1], wb_value[36:5], fetch_pc[45:37], zero fill[47:46]
   output logic [fsp_pkg::RspDataW-1:0]  rsp_tdata,
   // wb_valid[0]
   output logic [0:0]                    rsp_tuser,
   // finished
   output logic                          rsp_tlast,
   // program_length write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fsp_pkg::LenW-1:0]      csr_data
);

   localparam int RW    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int AW    = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
   localparam int PC_W  = $clog2(PROGRAM_DEPTH + 1);
   localparam int LEN_W = (PC_W > fsp_pkg::LenW) ? PC_W : fsp_pkg::LenW;
   localparam logic [LEN_W-1:0] DepthL = LEN_W'(PROGRAM_DEPTH);

   typedef struct packed {
      fsp_pkg::op_type         op;
      logic [RW-1:0]           rd;
      logic [RW-1:0]           ra;
      logic [RW-1:0]           rb;
      logic [DATA_WIDTH-1:0]   imm;
   } slot_type;

   // Register numbers wrap at REG_COUNT; the 4-bit field makes this a 16-entry table.
   function automatic logic [RW-1:0] reg_wrap(input logic [fsp_pkg::RegFldW-1:0] r);
      logic [RW-1:0] v;
      v = '0;
      for (int i = 0; i < 16; i++) begin
         if (r == fsp_pkg::RegFldW'(i)) v = RW'(i % REG_COUNT);
      end
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Storage
   // ------------------------------------------------------------------
   slot_type              pm_mem_ff [PROGRAM_DEPTH];
   logic [DATA_WIDTH-1:0] rf_mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0]  rf_vld_ff, rf_vld_in;

   logic [fsp_pkg::LenW-1:0] len_ff, len_in;
   logic [PC_W-1:0]          pc_ff, pc_in;

   // Decode latch: valid bit plus the program memory read register
   logic                  dec_vld_ff, dec_vld_in;
   slot_type              dec_ff;

   // Execute latch, and the register file operands read for it
   logic                  ex_vld_ff, ex_vld_in;
   slot_type              ex_ff, ex_in;
   logic [DATA_WIDTH-1:0] rfa_ff, rfb_ff;

   // Memory and writeback latches
   logic                  mem_vld_ff, mem_vld_in;
   logic [RW-1:0]         mem_rd_ff, mem_rd_in;
   logic [DATA_WIDTH-1:0] mem_val_ff, mem_val_in;
   logic                  wb_vld_ff, wb_vld_in;
   logic [RW-1:0]         wb_rd_ff, wb_rd_in;
   logic [DATA_WIDTH-1:0] wb_val_ff, wb_val_in;

   // Response register
   logic                          out_vld_ff, out_vld_in;
   logic [fsp_pkg::RspDataW-1:0]  out_data_ff, out_data_in;
   logic                          out_wbv_ff, out_wbv_in;
   logic                          out_fin_ff, out_fin_in;

   // ------------------------------------------------------------------
   // Handshakes and request decode
   // ------------------------------------------------------------------
   logic in_xfer, tick, load;
   logic [fsp_pkg::SlotW-1:0]   ld_slot;
   logic [LEN_W-1:0]            ld_slot_ext;
   logic                        ld_in_range;
   slot_type                    ld_word;

   // Accept while the response register is empty or drains this cycle.
   assign req_tready = !out_vld_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign in_xfer    = req_tvalid && req_tready;
   assign tick       = in_xfer && (fsp_pkg::kind_type'(req_tuser[0]) == fsp_pkg::KIND_TICK);
   assign load       = in_xfer && (fsp_pkg::kind_type'(req_tuser[0]) == fsp_pkg::KIND_LOAD);

   assign ld_slot     = req_tdata[fsp_pkg::ReqSlotLo +: fsp_pkg::SlotW];
   assign ld_slot_ext = LEN_W'(ld_slot);
   // Drop loads to slots beyond the program memory.
   assign ld_in_range = ld_slot_ext < DepthL;

   always_comb begin
      logic signed [fsp_pkg::ImmW-1:0] imm_s;
      imm_s      = signed'(req_tdata[fsp_pkg::ReqImmLo +: fsp_pkg::ImmW]);
      ld_word.op = fsp_pkg::op_type'(req_tdata[fsp_pkg::ReqOpLo +: 2]);
      ld_word.rd = reg_wrap(req_tdata[fsp_pkg::ReqRdLo +: fsp_pkg::RegFldW]);
      ld_word.ra = reg_wrap(req_tdata[fsp_pkg::ReqRaLo +: fsp_pkg::RegFldW]);
      ld_word.rb = reg_wrap(req_tdata[fsp_pkg::ReqRbLo +: fsp_pkg::RegFldW]);
      // Sign-extend the immediate to the datapath width.
      ld_word.imm = DATA_WIDTH'(imm_s);
   end

   // ------------------------------------------------------------------
   // Execute with forwarding: memory latch first, then writeback latch,
   // then the register file value read on the previous tick.
   // ------------------------------------------------------------------
   logic [DATA_WIDTH-1:0] opa, opb, ex_result;

   always_comb begin
      if (mem_vld_ff && mem_rd_ff == ex_ff.ra)      opa = mem_val_ff;
      else if (wb_vld_ff && wb_rd_ff == ex_ff.ra)   opa = wb_val_ff;
      else                                          opa = rfa_ff;

      if (mem_vld_ff && mem_rd_ff == ex_ff.rb)      opb = mem_val_ff;
      else if (wb_vld_ff && wb_rd_ff == ex_ff.rb)   opb = wb_val_ff;
      else                                          opb = rfb_ff;

      case (ex_ff.op)
         fsp_pkg::OP_ADD: ex_result = opa + opb;
         fsp_pkg::OP_SUB: ex_result = opa - opb;
         fsp_pkg::OP_MUL: ex_result = DATA_WIDTH'(opa * opb);
         default:         ex_result = ex_ff.imm;
      endcase
   end

   // ------------------------------------------------------------------
   // Hazard check and fetch control
   // ------------------------------------------------------------------
   logic             stall;
   logic [LEN_W-1:0] len_ext, eff_len, pc_ext;
   logic             can_fetch, fetch;

   // MOV reads no source, so it never waits on the instruction in execute.
   assign stall = dec_vld_ff && ex_vld_ff && (dec_ff.op != fsp_pkg::OP_MOV) &&
                  ((dec_ff.ra == ex_ff.rd) || (dec_ff.rb == ex_ff.rd));

   assign len_ext   = LEN_W'(len_ff);
   assign eff_len   = (len_ext < DepthL) ? len_ext : DepthL;
   assign pc_ext    = LEN_W'(pc_ff);
   // The PC saturates at the effective length; past it, fetch supplies bubbles.
   assign can_fetch = pc_ext < eff_len;
   assign fetch     = tick && !stall && can_fetch;

   // ------------------------------------------------------------------
   // Next state of the latches, PC and response
   // ------------------------------------------------------------------
   logic                       finished;
   logic [fsp_pkg::RegFldW-1:0] wb_reg_out;
   logic [fsp_pkg::WbValW-1:0]  wb_val_out;

   always_comb begin
      len_in     = len_ff;
      pc_in      = pc_ff;
      dec_vld_in = dec_vld_ff;
      ex_vld_in  = ex_vld_ff;
      ex_in      = ex_ff;
      mem_vld_in = mem_vld_ff;
      mem_rd_in  = mem_rd_ff;
      mem_val_in = mem_val_ff;
      wb_vld_in  = wb_vld_ff;
      wb_rd_in   = wb_rd_ff;
      wb_val_in  = wb_val_ff;
      rf_vld_in  = rf_vld_ff;

      if (csr_valid && csr_ready) len_in = csr_data;

      if (tick) begin
         // Writeback lands in the register file before anything else this tick.
         if (wb_vld_ff) rf_vld_in[wb_rd_ff] = 1'b1;

         // Advance the back half of the pipe.
         wb_vld_in  = mem_vld_ff;
         wb_rd_in   = mem_rd_ff;
         wb_val_in  = mem_val_ff;
         mem_vld_in = ex_vld_ff;
         mem_rd_in  = ex_ff.rd;
         mem_val_in = ex_result;

         if (stall) begin
            // Insert a bubble and hold decode and the PC.
            ex_vld_in = 1'b0;
         end else begin
            ex_vld_in  = dec_vld_ff;
            ex_in      = dec_ff;
            dec_vld_in = can_fetch;
            if (can_fetch) pc_in = pc_ff + PC_W'(1);
         end
      end
   end

   assign finished = (LEN_W'(pc_in) >= eff_len) && !dec_vld_in && !ex_vld_in &&
                     !mem_vld_in && !wb_vld_in;

   // Writeback fields read as zero when nothing is written back.
   assign wb_reg_out = wb_vld_ff ? fsp_pkg::RegFldW'(wb_rd_ff) : '0;
   assign wb_val_out = wb_vld_ff ? fsp_pkg::WbValW'(wb_val_ff) : '0;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_data_in = out_data_ff;
      out_wbv_in  = out_wbv_ff;
      out_fin_in  = out_fin_ff;
      if (rsp_tready) out_vld_in = 1'b0;
      if (tick) begin
         out_vld_in = 1'b1;
         out_data_in = '0;
         out_data_in[fsp_pkg::RspStallLo]                     = stall;
         out_data_in[fsp_pkg::RspRegLo +: fsp_pkg::RegFldW]   = wb_reg_out;
         out_data_in[fsp_pkg::RspValLo +: fsp_pkg::WbValW]    = wb_val_out;
         out_data_in[fsp_pkg::RspPcLo +: fsp_pkg::PcOutW]     = fsp_pkg::PcOutW'(pc_in);
         out_wbv_in = wb_vld_ff;
         out_fin_in = finished;
      end
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         pc_ff      <= '0;
         dec_vld_ff <= 1'b0;
         ex_vld_ff  <= 1'b0;
         mem_vld_ff <= 1'b0;
         wb_vld_ff  <= 1'b0;
         rf_vld_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         len_ff     <= len_in;
         pc_ff      <= pc_in;
         dec_vld_ff <= dec_vld_in;
         ex_vld_ff  <= ex_vld_in;
         mem_vld_ff <= mem_vld_in;
         wb_vld_ff  <= wb_vld_in;
         rf_vld_ff  <= rf_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ex_ff       <= ex_in;
      mem_rd_ff   <= mem_rd_in;
      mem_val_ff  <= mem_val_in;
      wb_rd_ff    <= wb_rd_in;
      wb_val_ff   <= wb_val_in;
      out_data_ff <= out_data_in;
      out_wbv_ff  <= out_wbv_in;
      out_fin_ff  <= out_fin_in;
   end

   // ------------------------------------------------------------------
   // Program memory: one write port for loads, one read port for fetch.
   // The read register is the decode latch payload.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (load && ld_in_range) pm_mem_ff[ld_slot_ext[AW-1:0]] <= ld_word;
      if (fetch) dec_ff <= pm_mem_ff[pc_ff[AW-1:0]];
   end

   // ------------------------------------------------------------------
   // Register file: writeback port plus two read ports for the instruction
   // leaving decode. Reads bypass this tick's writeback; unwritten entries
   // read as zero.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (tick && wb_vld_ff) rf_mem_ff[wb_rd_ff] <= wb_val_ff;
      if (tick) begin
         if (wb_vld_ff && wb_rd_ff == dec_ff.ra) rfa_ff <= wb_val_ff;
         else if (rf_vld_ff[dec_ff.ra])          rfa_ff <= rf_mem_ff[dec_ff.ra];
         else                                    rfa_ff <= '0;
         if (wb_vld_ff && wb_rd_ff == dec_ff.rb) rfb_ff <= wb_val_ff;
         else if (rf_vld_ff[dec_ff.rb])          rfb_ff <= rf_mem_ff[dec_ff.rb];
         else                                    rfb_ff <= '0;
      end
   end

   // ------------------------------------------------------------------
   // Result port
   // ------------------------------------------------------------------
   assign rsp_tvalid   = out_vld_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_wbv_ff;
   assign rsp_tlast    = out_fin_ff;

endmodule
